>>> rtl/slfc_pkg.sv
// Shared types, constants and the CRC-8 byte step for the framed burst checker.
// No dependencies; every rtl file imports this package.
package slfc_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hAA;
  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam int         LEN_POS     = 2;
  localparam int         PAYLOAD_POS = 3;
  localparam int         DESC_DEPTH  = 4;
  localparam int         OUT_DEPTH   = 3;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FORMAT = 2'd1,
    ST_CRC    = 2'd2
  } status_t;

  // One finished burst waiting to be drained.
  typedef struct packed {
    status_t status;
    logic    bank;
  } desc_t;

  // Payload buffer bank handed back once its last byte has been read.
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  // CRC-8, MSB first, one byte.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/slfc_drain.sv
// Result side of the framed burst checker: burst queue, double-banked payload
// memory and output queue. Depends on slfc_pkg.
module slfc_drain #(
  parameter int PAYLOAD_BYTES = 10,
  parameter int IDX_W         = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [IDX_W:0]       wr_addr,
  input  logic [7:0]           wr_data,
  input  logic                 desc_push,
  input  slfc_pkg::desc_t      desc_in,
  output logic                 desc_full,
  output slfc_pkg::release_t   rel,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [7:0]           payload_byte,
  output logic [3:0]           byte_index,
  output logic [1:0]           status,
  output logic                 last
);
  import slfc_pkg::*;

  localparam int MEM_DEPTH = 2 << IDX_W;

  typedef struct packed {
    status_t    status;
    logic [3:0] index;
    logic       last;
  } info_t;

  typedef struct packed {
    logic [7:0] payload;
    info_t      info;
  } res_t;

  // Payload memory: one write port (receive side), one registered read port.
  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] rdata;
  logic       rd_en;
  logic [IDX_W:0] rd_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Burst queue.
  desc_t      dq [DESC_DEPTH];
  logic [1:0] dq_wp;
  logic [1:0] dq_rp;
  logic [2:0] dq_cnt;
  logic       dq_pop;
  desc_t      head;

  assign head      = dq[dq_rp];
  assign desc_full = (dq_cnt == 3'(DESC_DEPTH));

  always_ff @(posedge clk) begin
    if (desc_push) begin
      dq[dq_wp] <= desc_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dq_wp  <= '0;
      dq_rp  <= '0;
      dq_cnt <= '0;
    end else begin
      if (desc_push) begin
        dq_wp <= dq_wp + 2'd1;
      end
      if (dq_pop) begin
        dq_rp <= dq_rp + 2'd1;
      end
      dq_cnt <= dq_cnt + 3'(desc_push) - 3'(dq_pop);
    end
  end

  // Issue stage: one result per cycle while the output queue has room.
  logic [IDX_W-1:0] idx;
  logic             pend;
  info_t            pend_info;
  logic [1:0]       oq_cnt;
  logic             issue;
  logic             idx_last;

  assign issue    = (dq_cnt != '0) && ((3'(oq_cnt) + 3'(pend)) < 3'(OUT_DEPTH));
  assign idx_last = (idx == IDX_W'(PAYLOAD_BYTES - 1));
  assign rd_en    = issue && (head.status == ST_OK);
  assign rd_addr  = {head.bank, idx};
  assign dq_pop   = issue && ((head.status != ST_OK) || idx_last);
  assign rel.valid = rd_en && idx_last;
  assign rel.bank  = head.bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      pend <= 1'b0;
    end else begin
      pend <= issue;
      if (rd_en) begin
        idx <= idx_last ? '0 : idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_info.status <= head.status;
      pend_info.index  <= (head.status == ST_OK) ? 4'(idx) : 4'd0;
      pend_info.last   <= (head.status != ST_OK) || idx_last;
    end
  end

  // Output queue.
  res_t       oq [OUT_DEPTH];
  logic [1:0] oq_wp;
  logic [1:0] oq_rp;
  logic       oq_pop;
  res_t       oq_in;

  assign oq_in.payload = (pend_info.status == ST_OK) ? rdata : 8'd0;
  assign oq_in.info    = pend_info;
  assign res_valid     = (oq_cnt != '0);
  assign oq_pop        = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (pend) begin
      oq[oq_wp] <= oq_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wp  <= '0;
      oq_rp  <= '0;
      oq_cnt <= '0;
    end else begin
      if (pend) begin
        oq_wp <= (oq_wp == 2'(OUT_DEPTH - 1)) ? 2'd0 : oq_wp + 2'd1;
      end
      if (oq_pop) begin
        oq_rp <= (oq_rp == 2'(OUT_DEPTH - 1)) ? 2'd0 : oq_rp + 2'd1;
      end
      oq_cnt <= oq_cnt + 2'(pend) - 2'(oq_pop);
    end
  end

  assign payload_byte = oq[oq_rp].payload;
  assign byte_index   = oq[oq_rp].info.index;
  assign status       = oq[oq_rp].info.status;
  assign last         = oq[oq_rp].info.last;

  a_dq_bound: assert property (@(posedge clk) disable iff (rst)
    dq_cnt <= 3'(DESC_DEPTH))
    else $error("burst queue overflow");

  a_credit: assert property (@(posedge clk) disable iff (rst)
    (3'(oq_cnt) + 3'(pend)) <= 3'(OUT_DEPTH))
    else $error("output queue overrun");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status != ST_OK) |-> last && (payload_byte == 8'd0))
    else $error("error result not single and final");

  a_pop_release: assert property (@(posedge clk) disable iff (rst)
    rel.valid |-> dq_pop)
    else $error("bank released without retiring its burst");

endmodule

>>> rtl/sync_length_crc8_frame_checker.sv
// Top level of the CRC-8 framed burst checker: per-burst checks and payload
// capture, with results drained by slfc_drain. Depends on slfc_pkg, slfc_drain.
//
//  channel | valid     | stall     | payload
//  rx      | rx_valid  | rx_stall  | rx_byte, burst_end
//  res     | res_valid | res_stall | payload_byte, byte_index, status, last
//
// One received byte is taken per cycle while rx_stall is low; the CRC step is a
// combinational unrolled byte update. A valid frame yields PAYLOAD_BYTES results,
// one per cycle while res_stall is low, read from a two-bank payload memory once
// the burst end is queued. The next burst fills the other bank while one drains;
// rx_stall rises only when both banks wait to be drained or the burst queue
// (four entries) is full. Reset is synchronous; no clearing pass is needed.
// A stalled result holds.
module sync_length_crc8_frame_checker #(
  parameter int FRAME_BYTES   = 14,
  parameter int PAYLOAD_BYTES = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  input  logic       burst_end,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] payload_byte,
  output logic [3:0] byte_index,
  output logic [1:0] status,
  output logic       last
);
  import slfc_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  // Per-burst state.
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       running_crc;
  logic             header_ok;
  logic             length_byte_ok;
  logic             crc_match;
  // Bank being filled, and banks holding a frame that still drains.
  logic             wr_bank;
  logic [1:0]       busy;

  logic             accept;
  logic             header_ok_next;
  logic             length_byte_ok_next;
  logic             crc_match_next;
  logic [7:0]       running_crc_next;
  logic [CNT_W-1:0] byte_count_next;
  logic [8:0]       off;
  logic             pl_wr;
  logic             len_ok;
  status_t          end_status;
  desc_t            desc;
  release_t         rel;
  logic             desc_full;
  logic             commit;

  // Hold input whenever the bank to fill is still draining or the queue is full.
  assign rx_stall = desc_full || busy[wr_bank];
  assign accept   = rx_valid && !rx_stall;

  always_comb begin
    header_ok_next = header_ok;
    if ((byte_count < CNT_W'(LEN_POS)) && (rx_byte != SYNC_BYTE)) begin
      header_ok_next = 1'b0;
    end
    length_byte_ok_next = length_byte_ok;
    if (byte_count == CNT_W'(LEN_POS)) begin
      length_byte_ok_next = (rx_byte == 8'(PAYLOAD_BYTES));
    end
    running_crc_next = running_crc;
    crc_match_next   = crc_match;
    if (byte_count < CNT_W'(FRAME_BYTES - 1)) begin
      running_crc_next = crc8_byte(running_crc, rx_byte);
    end else if (byte_count == CNT_W'(FRAME_BYTES - 1)) begin
      crc_match_next = (rx_byte == running_crc);
    end
    // Saturate the count at the frame length.
    byte_count_next = byte_count;
    if (byte_count < CNT_W'(FRAME_BYTES)) begin
      byte_count_next = byte_count + CNT_W'(1);
    end
  end

  // Payload positions follow the header and length byte.
  assign off   = 9'(byte_count) - 9'(PAYLOAD_POS);
  assign pl_wr = accept && (byte_count >= CNT_W'(PAYLOAD_POS))
                 && (9'(byte_count) < 9'(PAYLOAD_BYTES + PAYLOAD_POS));

  // Format errors take precedence over a CRC mismatch.
  assign len_ok = (byte_count == CNT_W'(FRAME_BYTES - 1));
  always_comb begin
    if (!len_ok || !header_ok_next || !length_byte_ok_next) begin
      end_status = ST_FORMAT;
    end else if (!crc_match_next) begin
      end_status = ST_CRC;
    end else begin
      end_status = ST_OK;
    end
  end

  assign desc.status = end_status;
  assign desc.bank   = wr_bank;
  assign commit      = accept && burst_end && (end_status == ST_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      running_crc    <= '0;
      header_ok      <= 1'b1;
      length_byte_ok <= 1'b0;
      crc_match      <= 1'b0;
    end else if (accept) begin
      if (burst_end) begin
        // Clear per-burst state at every burst end.
        byte_count     <= '0;
        running_crc    <= '0;
        header_ok      <= 1'b1;
        length_byte_ok <= 1'b0;
        crc_match      <= 1'b0;
      end else begin
        byte_count     <= byte_count_next;
        running_crc    <= running_crc_next;
        header_ok      <= header_ok_next;
        length_byte_ok <= length_byte_ok_next;
        crc_match      <= crc_match_next;
      end
    end
  end

  // Flip banks on a good frame; a bad burst leaves its bank free for reuse.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_bank <= 1'b0;
      busy    <= 2'b00;
    end else begin
      if (commit) begin
        wr_bank <= !wr_bank;
      end
      for (int i = 0; i < 2; i++) begin
        if (commit && (wr_bank == 1'(i))) begin
          busy[i] <= 1'b1;
        end else if (rel.valid && (rel.bank == 1'(i))) begin
          busy[i] <= 1'b0;
        end
      end
    end
  end

  slfc_drain #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .IDX_W         (IDX_W)
  ) u_drain (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (pl_wr),
    .wr_addr      ({wr_bank, off[IDX_W-1:0]}),
    .wr_data      (rx_byte),
    .desc_push    (accept && burst_end),
    .desc_in      (desc),
    .desc_full    (desc_full),
    .rel          (rel),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .status       (status),
    .last         (last)
  );

  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && burst_end |=> (byte_count == '0) && header_ok)
    else $error("burst state not cleared");

  a_no_fill_busy: assert property (@(posedge clk) disable iff (rst)
    pl_wr |-> !busy[wr_bank])
    else $error("write into a bank that is draining");

  a_bank_flip: assert property (@(posedge clk) disable iff (rst)
    commit |=> busy[$past(wr_bank)] && (wr_bank != $past(wr_bank)))
    else $error("good frame did not claim its bank");

endmodule
